@@ hdl/bpm_pkg.sv @@
`default_nettype none

package bpm_pkg;

    localparam int TICK_W       = 17;
    localparam int INFO_PAGES   = 3;
    localparam int MENU_ENTRIES = 3;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    localparam logic [1:0] ACTION_PAGE   = 2'd3;
    localparam logic [1:0] OVERVIEW_PAGE = 2'd0;
    localparam logic [1:0] LAST_INFO     = 2'(INFO_PAGES - 1);
    localparam logic [1:0] ENTRY_RESTART = 2'd0;
    localparam logic [1:0] ENTRY_SHUTDN  = 2'd1;
    localparam logic [1:0] LAST_ENTRY    = 2'(MENU_ENTRIES - 1);

    localparam logic [1:0] PRESS_NONE  = 2'd0;
    localparam logic [1:0] PRESS_SHORT = 2'd1;
    localparam logic [1:0] PRESS_LONG  = 2'd2;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TMO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REDRAW     = 3'd3;

    localparam logic [15:0] LONG_PRESS_RST = 16'd1000;
    localparam logic [9:0]  DEBOUNCE_RST   = 10'd30;
    localparam logic [16:0] IDLE_TMO_RST   = 17'd60000;
    localparam logic [15:0] REDRAW_RST     = 16'd500;

    typedef struct packed {
        logic [15:0] long_press_ticks;
        logic [9:0]  debounce_ticks;
        logic [16:0] idle_timeout_ticks;
        logic [15:0] redraw_interval_ticks;
    } cfg_t;

    typedef struct packed {
        logic       screen_on;
        logic [1:0] page_number;
        logic [1:0] menu_entry;
        logic [1:0] press_event;
        logic       redraw_request;
        logic       restart_request;
        logic       shutdown_request;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/button_press_menu_controller_unit.sv @@
// A tick beat accepted into the input register moves on to the result register, which drives the result port.
// Throughput: one tick beat per cycle, sustained, as long as the result side keeps taking beats.
// The input register and the result register each hold one beat; the result register
// decouples the two sides so the input register can take one more tick while a result waits.
// Reset (rst_n low, asynchronous): pipeline empty, registers back to defaults, screen on,
// overview page, first menu entry, all tick counters zero.
`default_nettype none

module button_press_menu_controller_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           button_level,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                screen_on,
    output logic [1:0]                          page_number,
    output logic [1:0]                          menu_entry,
    output logic [1:0]                          press_event,
    output logic                                redraw_request,
    output logic                                restart_request,
    output logic                                shutdown_request,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bpm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bpm_pkg::CFG_DATA_W-1:0] cfg_data
);

    bpm_pkg::cfg_t    cfg;
    bpm_pkg::result_t step_result;
    bpm_pkg::result_t res_reg;

    logic in_valid_reg;
    logic level_reg;
    logic out_valid_reg;
    logic advance;

    assign cfg_ready = 1'b1;

    // move the held tick into the result register when that slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    bpm_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    bpm_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .level   (level_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            level_reg <= button_level;
        if (advance)
            res_reg <= step_result;
    end

    assign out_valid        = out_valid_reg;
    assign screen_on        = res_reg.screen_on;
    assign page_number      = res_reg.page_number;
    assign menu_entry       = res_reg.menu_entry;
    assign press_event      = res_reg.press_event;
    assign redraw_request   = res_reg.redraw_request;
    assign restart_request  = res_reg.restart_request;
    assign shutdown_request = res_reg.shutdown_request;

endmodule

`default_nettype wire

@@ hdl/bpm_cfg.sv @@
`default_nettype none

module bpm_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             wr_en,
    input  wire logic [bpm_pkg::CFG_IDX_W-1:0]    wr_index,
    input  wire logic [bpm_pkg::CFG_DATA_W-1:0]   wr_data,
    output bpm_pkg::cfg_t                         cfg
);

    bpm_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ticks      <= bpm_pkg::LONG_PRESS_RST;
            cfg_reg.debounce_ticks        <= bpm_pkg::DEBOUNCE_RST;
            cfg_reg.idle_timeout_ticks    <= bpm_pkg::IDLE_TMO_RST;
            cfg_reg.redraw_interval_ticks <= bpm_pkg::REDRAW_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                bpm_pkg::REG_LONG_PRESS: cfg_reg.long_press_ticks      <= wr_data[15:0];
                bpm_pkg::REG_DEBOUNCE:   cfg_reg.debounce_ticks        <= wr_data[9:0];
                bpm_pkg::REG_IDLE_TMO:   cfg_reg.idle_timeout_ticks    <= wr_data[16:0];
                bpm_pkg::REG_REDRAW:     cfg_reg.redraw_interval_ticks <= wr_data[15:0];
                default: ;  // unknown index: dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ hdl/bpm_core.sv @@
`default_nettype none

module bpm_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step_en,
    input  wire logic           level,
    input  wire bpm_pkg::cfg_t  cfg,
    output bpm_pkg::result_t    result
);

    logic                       held_reg,  held_next;
    logic                       fired_reg, fired_next;
    logic [bpm_pkg::TICK_W-1:0] hold_reg,  hold_next;
    logic [bpm_pkg::TICK_W-1:0] idle_reg,  idle_next;
    logic [bpm_pkg::TICK_W-1:0] since_reg, since_next;
    logic                       power_reg, power_next;
    logic [1:0]                 page_reg,  page_next;
    logic [1:0]                 entry_reg, entry_next;

    logic [bpm_pkg::TICK_W-1:0] hold_inc, idle_inc, since_inc;
    logic                       long_hit, debounce_ok;
    logic [1:0]                 evt;
    logic                       redraw, restart, shutdown;

    assign hold_inc  = (hold_reg  == bpm_pkg::TICK_MAX) ? hold_reg  : hold_reg  + 1'b1;
    assign idle_inc  = (idle_reg  == bpm_pkg::TICK_MAX) ? idle_reg  : idle_reg  + 1'b1;
    assign since_inc = (since_reg == bpm_pkg::TICK_MAX) ? since_reg : since_reg + 1'b1;

    assign long_hit    = hold_inc >= {1'b0, cfg.long_press_ticks};
    assign debounce_ok = hold_inc >= {7'd0, cfg.debounce_ticks};

    always_comb
    begin
        held_next  = held_reg;
        fired_next = fired_reg;
        hold_next  = hold_inc;
        idle_next  = idle_inc;
        since_next = since_inc;
        power_next = power_reg;
        page_next  = page_reg;
        entry_next = entry_reg;
        evt        = bpm_pkg::PRESS_NONE;
        redraw     = 1'b0;
        restart    = 1'b0;
        shutdown   = 1'b0;

        if (level && !held_reg)
        begin
            held_next  = 1'b1;
            fired_next = 1'b0;
            hold_next  = '0;
        end
        else if (level && !fired_reg && long_hit)
        begin
            fired_next = 1'b1;
            idle_next  = '0;
            evt        = bpm_pkg::PRESS_LONG;
            if (!power_reg)
            begin
                power_next = 1'b1;
                redraw     = 1'b1;
            end
            else if (page_reg != bpm_pkg::ACTION_PAGE)
            begin
                page_next  = bpm_pkg::ACTION_PAGE;
                entry_next = bpm_pkg::ENTRY_RESTART;
                redraw     = 1'b1;
            end
            else if (entry_reg == bpm_pkg::ENTRY_RESTART)
                restart = 1'b1;
            else if (entry_reg == bpm_pkg::ENTRY_SHUTDN)
                shutdown = 1'b1;
            else
            begin
                page_next  = bpm_pkg::OVERVIEW_PAGE;
                entry_next = bpm_pkg::ENTRY_RESTART;
                redraw     = 1'b1;
            end
        end
        else if (!level && held_reg)
        begin
            held_next = 1'b0;
            if (!fired_reg && debounce_ok)
            begin
                idle_next = '0;
                evt       = bpm_pkg::PRESS_SHORT;
                redraw    = 1'b1;
                if (!power_reg)
                    power_next = 1'b1;
                else if (page_reg == bpm_pkg::ACTION_PAGE)
                    entry_next = (entry_reg == bpm_pkg::LAST_ENTRY) ? bpm_pkg::ENTRY_RESTART
                                                                   : entry_reg + 2'd1;
                else
                    page_next = (page_reg == bpm_pkg::LAST_INFO) ? bpm_pkg::OVERVIEW_PAGE
                                                                : page_reg + 2'd1;
            end
        end

        if (redraw)
            since_next = '0;

        if (power_next && idle_next > cfg.idle_timeout_ticks)
            power_next = 1'b0;

        if (power_next && since_next >= {1'b0, cfg.redraw_interval_ticks})
        begin
            since_next = '0;
            redraw     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= 1'b0;
            fired_reg <= 1'b0;
            hold_reg  <= '0;
            idle_reg  <= '0;
            since_reg <= '0;
            power_reg <= 1'b1;
            page_reg  <= bpm_pkg::OVERVIEW_PAGE;
            entry_reg <= bpm_pkg::ENTRY_RESTART;
        end
        else if (step_en)
        begin
            held_reg  <= held_next;
            fired_reg <= fired_next;
            hold_reg  <= hold_next;
            idle_reg  <= idle_next;
            since_reg <= since_next;
            power_reg <= power_next;
            page_reg  <= page_next;
            entry_reg <= entry_next;
        end
    end

    always_comb
    begin
        result.screen_on        = power_next;
        result.page_number      = page_next;
        result.menu_entry       = entry_next;
        result.press_event      = evt;
        result.redraw_request   = redraw;
        result.restart_request  = restart;
        result.shutdown_request = shutdown;
    end

endmodule

`default_nettype wire

@@ hdl/bpm_checker.sv @@
`default_nettype none

module bpm_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       screen_on,
    input wire logic [1:0] page_number,
    input wire logic [1:0] menu_entry,
    input wire logic [1:0] press_event,
    input wire logic       redraw_request,
    input wire logic       restart_request,
    input wire logic       shutdown_request
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(page_number) && $stable(menu_entry)
            && $stable(press_event) && $stable(screen_on))
        else $error("result beat changed while stalled");

    // an action request only comes from a long press on the action page, screen on
    a_action_src: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (restart_request || shutdown_request) |->
            press_event == bpm_pkg::PRESS_LONG && page_number == bpm_pkg::ACTION_PAGE
            && screen_on)
        else $error("action request without long press on action page");

    a_action_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(restart_request && shutdown_request))
        else $error("restart and shutdown in the same beat");

    // a short press always asks for a redraw, and the menu entry stays below 3
    a_short_redraw: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && press_event == bpm_pkg::PRESS_SHORT |-> redraw_request
            && menu_entry != 2'd3)
        else $error("short press without redraw");

endmodule

bind button_press_menu_controller_unit bpm_checker u_bpm_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .screen_on        (screen_on),
    .page_number      (page_number),
    .menu_entry       (menu_entry),
    .press_event      (press_event),
    .redraw_request   (redraw_request),
    .restart_request  (restart_request),
    .shutdown_request (shutdown_request)
);

`default_nettype wire
